// ----- rtl/core/bhge_pkg.sv -----
`timescale 1ns / 1ps

package bhge_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int VALUE_BITS = 32;
	localparam int COORD_BITS = 24;
	localparam int WIDE_BITS  = 64;
	localparam int ACC_BITS   = 128;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EVAL = 1'b1;

	localparam logic [1:0] TAB_VALUE  = 2'd0;
	localparam logic [1:0] TAB_SLOPE0 = 2'd1;
	localparam logic [1:0] TAB_SLOPE1 = 2'd2;
	localparam logic [1:0] TAB_CROSS  = 2'd3;

	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ROWS = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_COLS = 2'd1;

	// Hermite basis, one row per weight, coefficients of 1, t, t^2, t^3.
	localparam int HERMITE [16] = '{1, 0, -3, 2, 0, 0, 3, -2, 0, 1, -2, 1, 0, 0, -1, 1};

	typedef struct packed {
		logic                         func;
		logic [1:0]                   table_select;
		logic [5:0]                   entry_row;
		logic [5:0]                   entry_col;
		logic signed [VALUE_BITS-1:0] entry_value;
		logic signed [COORD_BITS-1:0] query_x0;
		logic signed [COORD_BITS-1:0] query_x1;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] interp_value;
		logic                         saturated;
	} result_t;

	typedef struct packed {
		logic signed [WIDE_BITS-1:0] val;
		logic                        hit;
	} clip_t;

	function automatic logic signed [WIDE_BITS-1:0] hermite(input int k,
			input logic signed [WIDE_BITS-1:0] t, input logic signed [WIDE_BITS-1:0] t2,
			input logic signed [WIDE_BITS-1:0] t3);
		logic signed [WIDE_BITS-1:0] c0, c1, c2, c3;
		c0 = WIDE_BITS'(HERMITE[4*k]);
		c1 = WIDE_BITS'(HERMITE[4*k+1]);
		c2 = WIDE_BITS'(HERMITE[4*k+2]);
		c3 = WIDE_BITS'(HERMITE[4*k+3]);
		return (c0 <<< FRAC_BITS) + c1 * t + c2 * t2 + c3 * t3;
	endfunction

	function automatic clip_t clip_wide(input logic signed [ACC_BITS-1:0] v,
			input logic signed [ACC_BITS-1:0] lo, input logic signed [ACC_BITS-1:0] hi);
		clip_t r;
		r.val = v[WIDE_BITS-1:0];
		r.hit = 1'b0;
		if (v < lo) begin
			r.val = lo[WIDE_BITS-1:0];
			r.hit = 1'b1;
		end else if (v > hi) begin
			r.val = hi[WIDE_BITS-1:0];
			r.hit = 1'b1;
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/bhge_ram.sv -----
`timescale 1ns / 1ps

module bhge_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ----- rtl/core/bhge_mul.sv -----
`timescale 1ns / 1ps

// Signed 64 x 64 multiply in four passes of a 33 x 33 multiplier, upper halves first.
// The passes take upper x upper, upper x lower, lower x upper and lower x lower, and
// the sum is shifted up by 32 bits before the second and the fourth pass is added.
module bhge_mul import bhge_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic signed [WIDE_BITS-1:0] a,
	input  logic signed [WIDE_BITS-1:0] b,
	output logic                        done,
	output logic signed [ACC_BITS-1:0]  p
);

	logic [1:0]                 phase_q;
	logic                       done_q;
	logic signed [32:0]         ma;
	logic signed [32:0]         mb;
	logic signed [65:0]         prod;
	logic signed [ACC_BITS-1:0] prod_x;
	logic signed [ACC_BITS-1:0] acc_q;

	always_comb begin
		ma     = phase_q[1] ? $signed({1'b0, a[31:0]}) : $signed({a[63], a[63:32]});
		mb     = phase_q[0] ? $signed({1'b0, b[31:0]}) : $signed({b[63], b[63:32]});
		prod   = ma * mb;
		prod_x = {{(ACC_BITS-66){prod[65]}}, prod};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= en && (phase_q == 2'd3);
			if (en) begin
				phase_q <= phase_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (phase_q == 2'd0) begin
				acc_q <= prod_x;
			end else if (phase_q[0]) begin
				acc_q <= (acc_q <<< 32) + prod_x;
			end else begin
				acc_q <= acc_q + prod_x;
			end
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

// ----- rtl/core/bicubic_hermite_grid_eval_unit.sv -----
// A load word is written to its table in the cycle it is accepted.
// An evaluate word reads the sixteen corners from memory in ST_READ, then runs 24 products
// on the shared multiplier (basis, row and column steps) and ends in ST_FIN.
// The block takes no new word until the sequencer is back at rest, as that single multiplier
// serves every product; the sequencer holds in ST_FIN while a result word waits.
// Reset (arst_n low, asynchronous) empties the sequencer and the result register and sets
// both node counts to 64; the table memories are not cleared and hold garbage until written.
`timescale 1ns / 1ps

module bicubic_hermite_grid_eval_unit import bhge_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  item_t                     item,
	output logic                      result_valid,
	input  logic                      result_stall,
	output result_t                   result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [6:0]                cfg_data
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLS);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_BASIS = 3'd2;
	localparam logic [2:0] ST_ROW   = 3'd3;
	localparam logic [2:0] ST_COL   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	localparam logic signed [ACC_BITS-1:0] HALF    = 128'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [ACC_BITS-1:0] ROW_HI  = (128'sd1 <<< 62) - 128'sd1;
	localparam logic signed [ACC_BITS-1:0] ROW_LO  = -(128'sd1 <<< 62);
	localparam logic signed [ACC_BITS-1:0] OUT_HI  = (128'sd1 <<< (VALUE_BITS - 1)) - 128'sd1;
	localparam logic signed [ACC_BITS-1:0] OUT_LO  = -(128'sd1 <<< (VALUE_BITS - 1));

	logic [2:0] state_q;
	logic [4:0] cnt_q;
	logic [6:0] rows_q, cols_q;

	logic [RW-1:0] n0_q;
	logic [CW-1:0] n1_q;
	logic signed [WIDE_BITS-1:0] t0_q, t1_q, t2_q;
	logic signed [WIDE_BITS-1:0] ha_q [4];
	logic signed [WIDE_BITS-1:0] hb_q [4];
	logic signed [WIDE_BITS-1:0] rsum_q [4];
	logic signed [VALUE_BITS-1:0] corner_q [16];
	logic signed [ACC_BITS-1:0] acc_q;
	logic sat_q;
	result_t pend_q;
	result_t result_q;
	logic result_valid_q;

	// Configuration registers; the port never holds off a write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 7'd64;
			cols_q <= 7'd64;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ROWS: rows_q <= cfg_data;
				CFG_COLS: cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The block takes a new word only with the sequencer at rest.
	assign item_stall = (state_q != ST_IDLE);

	logic accept, load_accept, eval_accept;
	assign accept      = item_valid && !item_stall;
	assign load_accept = accept && (item.func == FUNC_LOAD);
	assign eval_accept = accept && (item.func == FUNC_EVAL);

	// Locate each coordinate: floor to a node, clamp to the nodes in use of its own axis
	// (a count below two acts as two) and keep the exact offset from that node.
	int rows_eff, cols_eff;
	logic signed [31:0] fl0, fl1, n0_c, n1_c;
	logic signed [WIDE_BITS-1:0] t0_c, t1_c;

	always_comb begin
		rows_eff = (rows_q < 7'd2) ? 2 : ((int'(rows_q) > MAX_ROWS) ? MAX_ROWS : int'(rows_q));
		cols_eff = (cols_q < 7'd2) ? 2 : ((int'(cols_q) > MAX_COLS) ? MAX_COLS : int'(cols_q));
		fl0 = 32'($signed(item.query_x0)) >>> FRAC_BITS;
		fl1 = 32'($signed(item.query_x1)) >>> FRAC_BITS;
		if (fl0 < 0) n0_c = 32'sd0;
		else if (fl0 > 32'(rows_eff - 2)) n0_c = 32'(rows_eff - 2);
		else n0_c = fl0;
		if (fl1 < 0) n1_c = 32'sd0;
		else if (fl1 > 32'(cols_eff - 2)) n1_c = 32'(cols_eff - 2);
		else n1_c = fl1;
		t0_c = WIDE_BITS'($signed(item.query_x0)) - (WIDE_BITS'(n0_c) <<< FRAC_BITS);
		t1_c = WIDE_BITS'($signed(item.query_x1)) - (WIDE_BITS'(n1_c) <<< FRAC_BITS);
	end

	// Table memories. A write outside the grid is dropped. Reads fetch one corner node of
	// all four tables at once, in the order (n0,n1), (n0,n1+1), (n0+1,n1), (n0+1,n1+1).
	logic [AW-1:0] waddr, raddr, addr;
	logic          wr_ok;
	logic [RW-1:0] rd_row;
	logic [CW-1:0] rd_col;
	logic [VALUE_BITS-1:0] rdata [4];

	always_comb begin
		wr_ok  = (32'(item.entry_row) < MAX_ROWS) && (32'(item.entry_col) < MAX_COLS);
		waddr  = AW'(32'(item.entry_row) * MAX_COLS + 32'(item.entry_col));
		rd_row = n0_q + RW'(cnt_q[1]);
		rd_col = n1_q + CW'(cnt_q[0]);
		raddr  = AW'(32'(rd_row) * MAX_COLS + 32'(rd_col));
		addr   = (state_q == ST_IDLE) ? waddr : raddr;
	end

	for (genvar k = 0; k < 4; k++) begin : g_tab
		bhge_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_ram (
			.clk  (clk),
			.we   (load_accept && wr_ok && (item.table_select == 2'(k))),
			.addr (addr),
			.wdata(item.entry_value),
			.rdata(rdata[k])
		);
	end

	// Shared multiplier. Operands come from registers picked by the step count and stay put
	// until the product is taken, which is why the unit rests in the cycle it reports done.
	logic mul_en, mul_done;
	logic signed [WIDE_BITS-1:0] mul_a, mul_b;
	logic signed [ACC_BITS-1:0]  mul_p;
	logic signed [VALUE_BITS-1:0] cur_corner;

	always_comb begin
		cur_corner = corner_q[cnt_q[3:0]];
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_BASIS: begin
				mul_a = cnt_q[0] ? t2_q : (cnt_q[1] ? t1_q : t0_q);
				mul_b = cnt_q[1] ? t1_q : t0_q;
			end
			ST_ROW: begin
				mul_a = {{(WIDE_BITS-VALUE_BITS){cur_corner[VALUE_BITS-1]}}, cur_corner};
				mul_b = hb_q[cnt_q[1:0]];
			end
			ST_COL: begin
				mul_a = ha_q[cnt_q[1:0]];
				mul_b = rsum_q[cnt_q[1:0]];
			end
			default: ;
		endcase
		mul_en = ((state_q == ST_BASIS) || (state_q == ST_ROW) || (state_q == ST_COL))
			&& !mul_done;
	end

	bhge_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (mul_en),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.p     (mul_p)
	);

	// Rounding of a fresh product (basis powers) and of the running sum (dot products).
	logic signed [ACC_BITS-1:0] rnd_p, acc_sum, rnd_s;
	logic signed [WIDE_BITS-1:0] basis_t;
	logic signed [WIDE_BITS-1:0] h_c [4];
	clip_t row_clip, out_clip;

	always_comb begin
		rnd_p   = (mul_p + HALF) >>> FRAC_BITS;
		acc_sum = acc_q + mul_p;
		rnd_s   = (acc_sum + HALF) >>> FRAC_BITS;
		basis_t = cnt_q[1] ? t1_q : t0_q;
		for (int k = 0; k < 4; k++) begin
			h_c[k] = hermite(k, basis_t, t2_q, rnd_p[WIDE_BITS-1:0]);
		end
		row_clip = clip_wide(rnd_s, ROW_LO, ROW_HI);
		out_clip = clip_wide(rnd_s, OUT_LO, OUT_HI);
	end

	logic [1:0] rd_slot;
	assign rd_slot = 2'(cnt_q - 5'd1);

	// Control state of the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (eval_accept) begin
						state_q <= ST_READ;
						cnt_q   <= '0;
					end
				end
				ST_READ: begin
					if (cnt_q == 5'd4) begin
						state_q <= ST_BASIS;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_BASIS: begin
					if (mul_done) begin
						if (cnt_q == 5'd3) begin
							state_q <= ST_ROW;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_q + 5'd1;
						end
					end
				end
				ST_ROW: begin
					if (mul_done) begin
						if (cnt_q == 5'd15) begin
							state_q <= ST_COL;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_q + 5'd1;
						end
					end
				end
				ST_COL: begin
					if (mul_done) begin
						if (cnt_q == 5'd3) begin
							state_q <= ST_FIN;
						end else begin
							cnt_q <= cnt_q + 5'd1;
						end
					end
				end
				ST_FIN: begin
					if (!result_valid_q || !result_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (eval_accept) begin
			n0_q  <= n0_c[RW-1:0];
			n1_q  <= n1_c[CW-1:0];
			t0_q  <= t0_c;
			t1_q  <= t1_c;
			sat_q <= 1'b0;
			acc_q <= '0;
		end
		if ((state_q == ST_READ) && (cnt_q != 5'd0)) begin
			// Value and slope1 words fill the top rows, slope0 and cross the bottom rows.
			corner_q[{1'b0, rd_slot[1], 1'b0, rd_slot[0]}] <= rdata[TAB_VALUE];
			corner_q[{1'b0, rd_slot[1], 1'b1, rd_slot[0]}] <= rdata[TAB_SLOPE1];
			corner_q[{1'b1, rd_slot[1], 1'b0, rd_slot[0]}] <= rdata[TAB_SLOPE0];
			corner_q[{1'b1, rd_slot[1], 1'b1, rd_slot[0]}] <= rdata[TAB_CROSS];
		end
		if (mul_done) begin
			unique case (state_q)
				ST_BASIS: begin
					if (!cnt_q[0]) begin
						t2_q <= rnd_p[WIDE_BITS-1:0];
					end else if (!cnt_q[1]) begin
						for (int k = 0; k < 4; k++) ha_q[k] <= h_c[k];
					end else begin
						for (int k = 0; k < 4; k++) hb_q[k] <= h_c[k];
					end
				end
				ST_ROW: begin
					if (cnt_q[1:0] == 2'd3) begin
						rsum_q[cnt_q[3:2]] <= row_clip.val;
						sat_q <= sat_q | row_clip.hit;
						acc_q <= '0;
					end else begin
						acc_q <= acc_sum;
					end
				end
				ST_COL: begin
					if (cnt_q[1:0] == 2'd3) begin
						pend_q.interp_value <= out_clip.val[VALUE_BITS-1:0];
						pend_q.saturated    <= sat_q | out_clip.hit;
					end else begin
						acc_q <= acc_sum;
					end
				end
				default: ;
			endcase
		end
		if ((state_q == ST_FIN) && (!result_valid_q || !result_stall)) begin
			result_q <= pend_q;
		end
	end

	// Output register: a waiting result does not hold off the next load word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && (!result_valid_q || !result_stall)) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- rtl/core/bhge_checker.sv -----
`timescale 1ns / 1ps

module bhge_checker import bhge_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// A stalled result word stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word withdrawn while stalled");

	// A stalled result word keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result word changed while stalled");

	// Reset leaves no result on offer.
	assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result offered during reset");

	// A load word never produces a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (item.func == FUNC_LOAD) && !result_valid
		|=> !result_valid)
		else $error("result appeared after a load word");

	// An evaluate word yields no result in the cycle after it is accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (item.func == FUNC_EVAL) && !result_valid
		|=> !result_valid)
		else $error("result appeared one cycle after an evaluate word");

endmodule

bind bicubic_hermite_grid_eval_unit bhge_checker u_bhge_checker (.*);
